/* hdl/rbc_pkg.sv */
// Shared types, constants and helper functions of the record block counter.
package rbc_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int DIV_W       = COUNT_WIDTH + 2;
	localparam int DCNT_W      = $clog2(DIV_W + 1);
	localparam int BLK_W       = 15;
	localparam int MUL_W       = 2 * BLK_W + 1;
	localparam int OUT_W       = 24;
	localparam int OP_W        = 2;
	localparam int BYTE_W      = 8;
	localparam int IN_TW       = 16;
	localparam int OUT_TW      = 64;
	localparam int OUT_PAD     = OUT_TW - 2 * OUT_W - BLK_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [OUT_W-1:0]       OUT_MAX   = '1;
	localparam logic [BYTE_W-1:0]      LINE_FEED = 8'h0A;
	localparam logic [BLK_W-1:0]       HDR_BYTES = 15'd4;

	localparam logic              RST_FORMAT = 1'b0;
	localparam logic [BLK_W-1:0]  RST_BLOCK  = 15'd3120;
	localparam logic [BLK_W-1:0]  RST_RECLEN = 15'd80;

	typedef enum logic [OP_W-1:0] {
		OP_FOLD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT     = 2'd0,
		REG_BLOCK_SIZE = 2'd1,
		REG_RECORD_LEN = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_EXEC,
		CMD_F_PB,
		CMD_F_OR,
		CMD_F_RC,
		CMD_F_TB,
		CMD_V_K,
		CMD_V_F,
		CMD_V_M,
		CMD_V_D,
		CMD_MUL,
		CMD_OPEN,
		CMD_V_LAST,
		CMD_FIN,
		CMD_DONE
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EXEC,
		ST_F_PB,
		ST_F_OR,
		ST_F_RC,
		ST_F_TB,
		ST_F_MUL,
		ST_F_OPEN,
		ST_V_K,
		ST_V_F,
		ST_V_SEL,
		ST_V_M,
		ST_V_D,
		ST_V_MUL,
		ST_V_OPEN,
		ST_V_LAST,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t cmd;
		logic div_start;
		logic in_ready;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic is_lf;
		logic line_zero;
		logic fmt_var;
		logic fix_ok;
		logic var_ok;
		logic div_busy;
		logic div_done;
		logic k_le_f;
		logic out_free;
	} dp_sts_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
			input logic [DIV_W-1:0] b);
		logic [DIV_W:0] s;
		s = (DIV_W + 1)'(a) + (DIV_W + 1)'(b);
		return (s > (DIV_W + 1)'(COUNT_MAX)) ? COUNT_MAX : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
	endfunction

endpackage

/* hdl/rbc_div.sv */
// Restoring divider, one quotient bit per cycle.
module rbc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rbc_pkg::DIV_W-1:0]  dividend,
	input  logic [rbc_pkg::BLK_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [rbc_pkg::DIV_W-1:0]  quotient,
	output logic [rbc_pkg::BLK_W-1:0]  remainder
);
	import rbc_pkg::*;

	logic [DIV_W-1:0]  quo_q;
	logic [BLK_W:0]    rem_q;
	logic [BLK_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BLK_W:0]    trial;
	logic              ge;

	assign trial = {rem_q[BLK_W-1:0], quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[BLK_W-1:0];

endmodule

/* hdl/rbc_dp.sv */
// Datapath: settings, committed estimate, placement scratch registers, output register.
module rbc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rbc_pkg::ctrl_cmd_t            cmd,
	output rbc_pkg::dp_sts_t              sts,
	input  logic                          s_tvalid,
	input  logic [rbc_pkg::IN_TW-1:0]     s_tdata,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [rbc_pkg::OUT_TW-1:0]    m_tdata,
	input  logic                          cfg_valid,
	input  logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbc_pkg::BLK_W-1:0]     cfg_data
);
	import rbc_pkg::*;

	logic                   fmt_q;
	logic [BLK_W-1:0]       bs_q;
	logic [BLK_W-1:0]       rl_q;
	op_t                    op_q;
	logic [BYTE_W-1:0]      byte_q;
	logic [COUNT_WIDTH-1:0] line_q;
	logic [COUNT_WIDTH-1:0] full_q;
	logic [BLK_W-1:0]       open_q;
	logic [COUNT_WIDTH-1:0] full_w_q;
	logic [BLK_W-1:0]       open_w_q;
	logic [BLK_W-1:0]       pb_q;
	logic [DIV_W-1:0]       t_q;
	logic [COUNT_WIDTH-1:0] k_q;
	logic [BLK_W-1:0]       rem_q;
	logic [BLK_W-1:0]       f_q;
	logic [BLK_W-1:0]       m_q;
	logic [BLK_W-1:0]       r_q;
	logic [MUL_W-1:0]       prod_q;
	logic                   out_valid_q;
	logic [OUT_TW-1:0]      out_data_q;

	logic                   in_accept;
	logic                   is_lf;
	logic                   line_zero;
	logic                   k_le_f;
	logic                   out_free;
	logic                   out_load;
	logic [BLK_W-1:0]       room;
	logic [DIV_W-1:0]       div_dvd;
	logic [BLK_W-1:0]       div_dvs;
	logic                   div_busy;
	logic                   div_done;
	logic [DIV_W-1:0]       div_quo;
	logic [BLK_W-1:0]       div_rem;
	logic [BLK_W:0]         mul_a;
	logic [BLK_W-1:0]       vl_rec;
	logic                   vl_over;
	logic                   need_last;
	logic [COUNT_WIDTH-1:0] full_sel;
	logic [BLK_W-1:0]       open_sel;
	logic [COUNT_WIDTH-1:0] tot;

	assign in_accept = s_tvalid && cmd.in_ready;
	assign is_lf     = byte_q == LINE_FEED;
	assign line_zero = line_q == '0;
	assign k_le_f    = k_q <= COUNT_WIDTH'(f_q);
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (cmd.cmd == CMD_DONE) && out_free;
	assign room      = (open_w_q > bs_q) ? '0 : (bs_q - open_w_q);
	assign need_last = line_zero || (rem_q != '0);
	assign vl_rec    = HDR_BYTES + rem_q;
	assign vl_over   = ((BLK_W + 2)'(open_w_q) + (BLK_W + 2)'(vl_rec)) > (BLK_W + 2)'(bs_q);

	always_comb begin
		sts.op        = op_q;
		sts.is_lf     = is_lf;
		sts.line_zero = line_zero;
		sts.fmt_var   = fmt_q;
		sts.fix_ok    = (rl_q != '0) && (bs_q >= rl_q);
		sts.var_ok    = (rl_q > HDR_BYTES) && (bs_q >= HDR_BYTES)
			&& (((BLK_W + 1)'(rl_q) + (BLK_W + 1)'(HDR_BYTES)) <= (BLK_W + 1)'(bs_q));
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.k_le_f    = k_le_f;
		sts.out_free  = out_free;
	end

	// divider operand select per placement step
	always_comb begin
		div_dvd = '0;
		div_dvs = rl_q;
		unique case (cmd.cmd)
			CMD_F_PB: div_dvd = DIV_W'(bs_q);
			CMD_F_OR: div_dvd = DIV_W'(open_w_q);
			CMD_F_RC: div_dvd = line_zero ? '0
				: (DIV_W'(line_q) + DIV_W'(rl_q) - DIV_W'(1));
			CMD_F_TB: begin
				div_dvd = t_q;
				div_dvs = pb_q;
			end
			CMD_V_K: begin
				div_dvd = DIV_W'(line_q);
				div_dvs = rl_q - HDR_BYTES;
			end
			CMD_V_F: div_dvd = DIV_W'(room);
			CMD_V_M: div_dvd = DIV_W'(bs_q - HDR_BYTES);
			CMD_V_D: begin
				div_dvd = DIV_W'(k_q - COUNT_WIDTH'(f_q) - COUNT_WIDTH'(1));
				div_dvs = m_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (!fmt_q)
			mul_a = {1'b0, r_q};
		else if (k_le_f)
			mul_a = {1'b0, k_q[BLK_W-1:0]};
		else
			mul_a = {1'b0, r_q} + (BLK_W + 1)'(1);
	end

	always_comb begin
		full_sel = (op_q == OP_QUERY) ? full_w_q : full_q;
		open_sel = (op_q == OP_QUERY) ? open_w_q : open_q;
		tot      = sat_add(full_sel, DIV_W'(open_sel != '0));
	end

	rbc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= RST_FORMAT;
			bs_q        <= RST_BLOCK;
			rl_q        <= RST_RECLEN;
			line_q      <= '0;
			full_q      <= '0;
			open_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FORMAT:     fmt_q <= cfg_data[0];
					REG_BLOCK_SIZE: bs_q  <= cfg_data;
					REG_RECORD_LEN: rl_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.cmd == CMD_EXEC) begin
				if (op_q == OP_FOLD && !is_lf) begin
					line_q <= sat_add(line_q, DIV_W'(1));
				end else if (op_q == OP_CLEAR) begin
					line_q <= '0;
					full_q <= '0;
					open_q <= '0;
				end
			end
			// a query leaves the committed estimate alone
			if (cmd.cmd == CMD_FIN && op_q == OP_FOLD) begin
				full_q <= full_w_q;
				open_q <= open_w_q;
				line_q <= '0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= op_t'(s_tdata[OP_W-1:0]);
			byte_q <= s_tdata[OP_W+BYTE_W-1:OP_W];
		end
		if (out_load)
			out_data_q <= {{OUT_PAD{1'b0}}, clamp_out(line_q), open_q, clamp_out(tot)};
		unique case (cmd.cmd)
			CMD_EXEC: begin
				full_w_q <= full_q;
				open_w_q <= open_q;
			end
			CMD_F_PB: if (div_done) pb_q <= div_quo[BLK_W-1:0];
			CMD_F_OR: if (div_done) t_q <= div_quo;
			CMD_F_RC: if (div_done) t_q <= t_q + (line_zero ? DIV_W'(1) : div_quo);
			CMD_F_TB: begin
				if (div_done) begin
					full_w_q <= sat_add(full_w_q, div_quo);
					r_q      <= div_rem;
				end
			end
			CMD_V_K: begin
				if (div_done) begin
					k_q      <= div_quo[COUNT_WIDTH-1:0];
					rem_q    <= div_rem;
					open_w_q <= (open_w_q == '0) ? HDR_BYTES : open_w_q;
				end
			end
			CMD_V_F: if (div_done) f_q <= div_quo[BLK_W-1:0];
			CMD_V_M: if (div_done) m_q <= div_quo[BLK_W-1:0];
			CMD_V_D: begin
				// blocks opened past the current one, last one partly filled
				if (div_done) begin
					full_w_q <= sat_add(full_w_q, div_quo + DIV_W'(1));
					r_q      <= div_rem;
				end
			end
			CMD_MUL: prod_q <= MUL_W'(mul_a) * MUL_W'(rl_q);
			CMD_OPEN: begin
				if (!fmt_q)
					open_w_q <= prod_q[BLK_W-1:0];
				else
					open_w_q <= (k_le_f ? open_w_q : HDR_BYTES) + prod_q[BLK_W-1:0];
			end
			CMD_V_LAST: begin
				// short tail record, or the lone header of an empty line
				if (need_last) begin
					if (vl_over) begin
						full_w_q <= sat_add(full_w_q, DIV_W'(1));
						open_w_q <= HDR_BYTES + vl_rec;
					end else begin
						open_w_q <= open_w_q + vl_rec;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* hdl/rbc_ctrl.sv */
// Controller: sequences the placement steps and the shared divider.
module rbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  rbc_pkg::dp_sts_t    sts,
	output rbc_pkg::ctrl_cmd_t  cmd
);
	import rbc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   div_state;
	logic   place;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign place = (sts.op == OP_FOLD && sts.is_lf) || (sts.op == OP_QUERY && !sts.line_zero);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (!place)
					state_d = ST_DONE;
				else if (sts.fmt_var)
					state_d = sts.var_ok ? ST_V_K : ST_FIN;
				else
					state_d = sts.fix_ok ? ST_F_PB : ST_FIN;
			end
			ST_F_PB:   if (sts.div_done) state_d = ST_F_OR;
			ST_F_OR:   if (sts.div_done) state_d = ST_F_RC;
			ST_F_RC:   if (sts.div_done) state_d = ST_F_TB;
			ST_F_TB:   if (sts.div_done) state_d = ST_F_MUL;
			ST_F_MUL:  state_d = ST_F_OPEN;
			ST_F_OPEN: state_d = ST_FIN;
			ST_V_K:    if (sts.div_done) state_d = ST_V_F;
			ST_V_F:    if (sts.div_done) state_d = ST_V_SEL;
			ST_V_SEL:  state_d = sts.k_le_f ? ST_V_MUL : ST_V_M;
			ST_V_M:    if (sts.div_done) state_d = ST_V_D;
			ST_V_D:    if (sts.div_done) state_d = ST_V_MUL;
			ST_V_MUL:  state_d = ST_V_OPEN;
			ST_V_OPEN: state_d = ST_V_LAST;
			ST_V_LAST: state_d = ST_FIN;
			ST_FIN:    state_d = ST_DONE;
			ST_DONE:   if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign div_state = (state_q == ST_F_PB) || (state_q == ST_F_OR) || (state_q == ST_F_RC)
		|| (state_q == ST_F_TB) || (state_q == ST_V_K) || (state_q == ST_V_F)
		|| (state_q == ST_V_M) || (state_q == ST_V_D);

	always_comb begin
		cmd.in_ready  = 1'b0;
		cmd.div_start = div_state && !sts.div_busy && !sts.div_done;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cmd      = CMD_NONE;
				cmd.in_ready = 1'b1;
			end
			ST_EXEC:   cmd.cmd = CMD_EXEC;
			ST_F_PB:   cmd.cmd = CMD_F_PB;
			ST_F_OR:   cmd.cmd = CMD_F_OR;
			ST_F_RC:   cmd.cmd = CMD_F_RC;
			ST_F_TB:   cmd.cmd = CMD_F_TB;
			ST_F_MUL:  cmd.cmd = CMD_MUL;
			ST_F_OPEN: cmd.cmd = CMD_OPEN;
			ST_V_K:    cmd.cmd = CMD_V_K;
			ST_V_F:    cmd.cmd = CMD_V_F;
			ST_V_SEL:  cmd.cmd = CMD_NONE;
			ST_V_M:    cmd.cmd = CMD_V_M;
			ST_V_D:    cmd.cmd = CMD_V_D;
			ST_V_MUL:  cmd.cmd = CMD_MUL;
			ST_V_OPEN: cmd.cmd = CMD_OPEN;
			ST_V_LAST: cmd.cmd = CMD_V_LAST;
			ST_FIN:    cmd.cmd = CMD_FIN;
			ST_DONE:   cmd.cmd = CMD_DONE;
			default:   cmd.cmd = CMD_NONE;
		endcase
	end

endmodule

/* hdl/record_block_counter.sv */
// Top level of the record block counter: controller plus datapath.
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: opcode, data_byte
//  m_*      | out | m_tvalid/m_tready  | m_tdata: total_blocks, partial_block_bytes,
//           |     |                    |          pending_line_chars
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat at a time. A plain byte, clear or idle query passes through idle, execute and
// result load before the next accept. A line end (or a query with a pending line)
// runs the placement through one shared radix-2 divider of COUNT_WIDTH+2 bits: four
// divisions in fixed format, two or four in variable format, with control steps between.
// Reset clears the estimate and loads the default settings; no clearing pass.
// The result register lets the next beat in while a result waits; a stalled
// m_tready holds the block only when the next result is ready to load.
module record_block_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rbc_pkg::IN_TW-1:0]     s_tdata,   // [1:0] opcode, [9:2] data_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rbc_pkg::OUT_TW-1:0]    m_tdata,   // [23:0] total_blocks,
	                                                 // [38:24] partial_block_bytes,
	                                                 // [62:39] pending_line_chars
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbc_pkg::BLK_W-1:0]     cfg_data
);
	import rbc_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	assign s_tready  = cmd.in_ready;
	assign cfg_ready = 1'b1;

	rbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

/* hdl/rbc_checker.sv */
// Port-level checks of the record block counter, bound to the top level.
module rbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rbc_pkg::OUT_TW-1:0]    m_tdata
);
	import rbc_pkg::*;

	// one beat in flight: no back-to-back accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// a new result appears as the block returns to ready
	a_result_at_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result loaded while still busy");

	// an open block is always counted in the total
	a_open_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[OUT_W+BLK_W-1:OUT_W] != '0) |-> (m_tdata[OUT_W-1:0] != '0))
		else $error("open block not counted in total");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

endmodule

bind record_block_counter rbc_checker u_rbc_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the record block counter: byte stream in, block estimates out.
`timescale 1ns / 100ps

module tb_top;
	import rbc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600_000;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_TW-1:0]     s_tdata   = '0;   // [1:0] opcode, [9:2] data_byte
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_TW-1:0]    m_tdata;          // [23:0] total_blocks, [38:24] partial_block_bytes,
	                                        // [62:39] pending_line_chars
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BLK_W-1:0]     cfg_data  = '0;

	int unsigned cycles = 0;
	bit          send_burst = 1'b0;
	bit          recv_burst = 1'b0;

	record_block_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	class block_estimate_board;
		typedef struct packed {
			logic [OUT_W-1:0] total;
			logic [BLK_W-1:0] partial;
			logic [OUT_W-1:0] pending;
		} estimate_t;

		bit          var_format;
		int unsigned block_bytes;
		int unsigned rec_bytes;
		int unsigned line_chars;
		int unsigned blocks_done;
		int unsigned open_bytes;
		estimate_t   expected_estimates[$];
		int unsigned failures;
		int unsigned beats_in;
		int unsigned results_seen;
		int unsigned line_ends;
		int unsigned queries;
		int unsigned settings_seen;

		function new();
			var_format  = RST_FORMAT;
			block_bytes = 32'(RST_BLOCK);
			rec_bytes   = 32'(RST_RECLEN);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [BLK_W-1:0] val);
			case (idx)
				REG_FORMAT:     var_format  = val[0];
				REG_BLOCK_SIZE: block_bytes = 32'(val);
				REG_RECORD_LEN: rec_bytes   = 32'(val);
				default: ;
			endcase
		endfunction

		function int unsigned sat_count(int unsigned a, longint unsigned b);
			longint unsigned s;
			s = 64'(a) + b;
			return (s > 64'(COUNT_MAX)) ? 32'(COUNT_MAX) : 32'(s);
		endfunction

		// whole records per block; the open block is re-read as records of the current length
		function void place_fixed(inout int unsigned full, inout int unsigned open,
				input int unsigned n);
			longint unsigned per_blk;
			longint unsigned recs;
			longint unsigned total;
			if (rec_bytes == 0)
				return;
			per_blk = block_bytes / rec_bytes;
			if (per_blk == 0)
				return;
			recs  = (n == 0) ? 1 : (64'(n) + rec_bytes - 1) / rec_bytes;
			total = open / rec_bytes + recs;
			full  = sat_count(full, total / per_blk);
			open  = 32'((total % per_blk) * rec_bytes);
		endfunction

		function void place_variable(inout int unsigned full, inout int unsigned open,
				input int unsigned n);
			int unsigned hdr;
			int unsigned cap;
			int unsigned left;
			int unsigned chunk;
			int unsigned rec;
			int unsigned nrecs;
			hdr = 32'(HDR_BYTES);
			if (rec_bytes <= hdr || block_bytes < hdr || rec_bytes > block_bytes - hdr)
				return;
			cap   = rec_bytes - hdr;
			nrecs = (n == 0) ? 1 : 32'((64'(n) + cap - 1) / cap);
			left  = n;
			for (int unsigned i = 0; i < nrecs; i++) begin
				chunk = (left > cap) ? cap : left;
				left -= chunk;
				rec = hdr + chunk;
				if (open == 0)
					open = hdr;   // fresh block starts with its BDW
				if (64'(open) + rec > block_bytes) begin
					full = sat_count(full, 1);
					open = hdr + rec;
				end else begin
					open += rec;
				end
			end
		endfunction

		function void place_line(inout int unsigned full, inout int unsigned open,
				input int unsigned n);
			if (var_format)
				place_variable(full, open, n);
			else
				place_fixed(full, open, n);
		endfunction

		function void note_input(op_t op, logic [BYTE_W-1:0] d);
			estimate_t   e;
			int unsigned full;
			int unsigned open;
			beats_in++;
			case (op)
				OP_FOLD: begin
					if (d == LINE_FEED) begin
						place_line(blocks_done, open_bytes, line_chars);
						line_chars = 0;
						line_ends++;
					end else begin
						line_chars = sat_count(line_chars, 1);
					end
				end
				OP_CLEAR: begin
					line_chars  = 0;
					blocks_done = 0;
					open_bytes  = 0;
				end
				default: ;
			endcase
			full = blocks_done;
			open = open_bytes;
			if (op == OP_QUERY) begin
				queries++;
				// trailing line counted on a scratch copy only
				if (line_chars > 0)
					place_line(full, open, line_chars);
			end
			e.total   = OUT_W'(sat_count(full, (open > 0) ? 1 : 0));
			e.partial = BLK_W'(open_bytes);
			e.pending = OUT_W'(line_chars);
			expected_estimates.push_back(e);
		endfunction

		function void check_result(logic [OUT_TW-1:0] td);
			estimate_t want;
			estimate_t got;
			got.total   = td[OUT_W-1:0];
			got.partial = td[OUT_W +: BLK_W];
			got.pending = td[OUT_W+BLK_W +: OUT_W];
			results_seen++;
			if (expected_estimates.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] result with none outstanding: total=%0d partial=%0d pending=%0d",
						$time, got.total, got.partial, got.pending);
				return;
			end
			want = expected_estimates.pop_front();
			if (got.total !== want.total || got.partial !== want.partial ||
					got.pending !== want.pending) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] estimate mismatch: exp total=%0d partial=%0d pending=%0d, %s%0d %s%0d %s%0d",
						$time, want.total, want.partial, want.pending,
						"got total=", got.total, "partial=", got.partial,
						"pending=", got.pending);
			end
		endfunction
	endclass

	block_estimate_board sb;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				sb.expected_estimates.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);

	// result side: random stalls per beat, with stretches of none
	initial begin
		int unsigned hold;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_burst = !recv_burst;
			hold = recv_burst ? 0 : $urandom_range(0, 18);
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_item(input op_t op, input logic [BYTE_W-1:0] d);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			if (s_tvalid)
				s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TW'({d, op});
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, d);
	endtask

	task automatic wait_drained();
		while (sb.expected_estimates.size() > 0)
			@(posedge clk);
	endtask

	task automatic cfg_beat(input cfg_reg_t idx, input logic [BLK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_settings(input bit fmt, input int unsigned bs, input int unsigned rl);
		s_tvalid <= 1'b0;
		wait_drained();
		cfg_beat(REG_FORMAT, BLK_W'(fmt));
		cfg_beat(REG_BLOCK_SIZE, BLK_W'(bs));
		cfg_beat(REG_RECORD_LEN, BLK_W'(rl));
		cfg_valid <= 1'b0;
		sb.settings_seen++;
	endtask

	// mostly whole lines of random text, with queries, clears, reserved ops and raw bytes mixed in
	task automatic send_random(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 12);
				repeat (len) begin
					b = BYTE_W'($urandom_range(0, 255));
					if (b == LINE_FEED)
						b = ~b;
					send_item(OP_FOLD, b);
					if ($urandom_range(0, 15) == 0)
						send_item(OP_QUERY, BYTE_W'($urandom));
				end
				send_item(OP_FOLD, LINE_FEED);
				sent += len + 1;
			end else if (pick < 80) begin
				send_item(OP_QUERY, BYTE_W'($urandom));
				sent++;
			end else if (pick < 85) begin
				send_item(OP_CLEAR, BYTE_W'($urandom));
				sent++;
			end else if (pick < 90) begin
				send_item(OP_RSVD, BYTE_W'($urandom));
				sent++;
			end else if (pick < 98) begin
				send_item(OP_FOLD, BYTE_W'($urandom));
				sent++;
			end else begin
				// hold off until every outstanding result is back
				s_tvalid <= 1'b0;
				wait_drained();
			end
		end
	endtask

	initial begin
		int unsigned plan[11][3] = '{
			'{1, 32760, 32760},
			'{0, 1, 1},
			'{1, 9, 5},
			'{0, 32760, 1},
			'{1, 32760, 32756},
			'{0, 100, 200},
			'{1, 3, 5},
			'{1, 200, 4},
			'{1, 300, 40},
			'{0, 1000, 7},
			'{0, 32760, 32760}
		};
		int unsigned bs;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fixed 80-byte records in 3120-byte blocks
		send_item(OP_FOLD, 8'h00);
		send_item(OP_FOLD, 8'hFF);
		send_item(OP_QUERY, 8'h00);
		send_item(OP_FOLD, LINE_FEED);
		send_item(OP_FOLD, LINE_FEED);   // empty line still takes a record
		send_item(OP_QUERY, 8'h55);
		send_item(OP_RSVD, 8'hAA);
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_FOLD, LINE_FEED);
		send_random(30);

		// smallest valid variable layout: one data byte per record
		apply_settings(1'b1, 9, 5);
		send_item(OP_FOLD, 8'h61);
		send_item(OP_FOLD, 8'h62);
		send_item(OP_FOLD, 8'h63);
		send_item(OP_QUERY, 8'h00);
		send_item(OP_FOLD, LINE_FEED);
		send_item(OP_FOLD, 8'h78);
		send_item(OP_QUERY, 8'hFF);

		// fixed with block smaller than record: line ends add no blocks
		apply_settings(1'b0, 100, 200);
		send_item(OP_FOLD, LINE_FEED);
		send_item(OP_FOLD, 8'h7A);
		send_item(OP_QUERY, 8'h0A);
		send_item(OP_FOLD, LINE_FEED);

		foreach (plan[i]) begin
			apply_settings(plan[i][0][0], plan[i][1], plan[i][2]);
			send_random(27);
		end
		repeat (3) begin
			bs = $urandom_range(1, 32760);
			apply_settings(1'($urandom_range(0, 1)), bs,
				($urandom_range(0, 1) == 0) ? $urandom_range(1, bs) : $urandom_range(1, 32760));
			send_random(27);
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (sb.expected_estimates.size() > 0) begin
			$display("%0d expected results never arrived", sb.expected_estimates.size());
			sb.failures += sb.expected_estimates.size();
		end
		$display("Checked %0d results for %0d input beats over %0d register settings,",
			sb.results_seen, sb.beats_in, sb.settings_seen + 1);
		$display("including %0d line ends and %0d queries; %0d mismatches.",
			sb.line_ends, sb.queries, sb.failures);
		if (sb.failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
